/* rtl/core/pan_tilt_tracking_controller_macros.svh */
// Assertion macros for the pan/tilt tracking controller.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef PAN_TILT_TRACKING_CONTROLLER_MACROS_SVH
`define PAN_TILT_TRACKING_CONTROLLER_MACROS_SVH

// same-cycle implication, masked during reset
`define PTT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pan/tilt controller assertion failed");

// next-cycle implication, masked during reset
`define PTT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pan/tilt controller assertion failed");

`endif

/* rtl/core/ptt_pkg.sv */
// Shared widths, constants and types of the pan/tilt tracking controller.
// No dependencies.
`default_nettype none

package ptt_pkg;

  localparam int unsigned POS_FRAC_BITS  = 12;
  localparam int unsigned GAIN_FRAC_BITS = 16;
  localparam int unsigned GAIN_W         = 20;
  localparam int unsigned DB_W           = 12;
  localparam int unsigned RUN_W          = 8;
  localparam int unsigned DELAY_W        = 20;
  // shared multiplier: gain by one chunk of the operand magnitude, or delay by the reciprocal
  localparam int unsigned CHUNK_W        = 24;
  localparam int unsigned MUL_P_W        = GAIN_W + CHUNK_W;
  // control value: three terms of up to 2^60 each
  localparam int unsigned C_W            = 63;
  localparam int unsigned DIV_W          = C_W - 1;

  localparam logic [DELAY_W-1:0] DELAY_MAX = 20'd1000000;

  // 1000 in Q.(POS+GAIN); delay = DIV_NUM / |C|
  localparam logic [63:0] DIV_NUM   = 64'(1000) << (POS_FRAC_BITS + GAIN_FRAC_BITS);
  // |C| at or below this gives a quotient above DELAY_MAX
  localparam logic [63:0] DIV_SAT_T = DIV_NUM / (64'(DELAY_MAX) + 64'd1);

  typedef struct packed {
    logic busy;
    logic done;
  } ptt_div_stat_t;

endpackage

`default_nettype wire

/* rtl/core/pan_tilt_tracking_controller.sv */
// Tracking update, per axis: three gain terms on the shared multiplier, each taken in
// ceil(INTEGRAL_WIDTH/24) chunks, then the serial divider, which is skipped when the
// control saturates the delay. Manual event: one output beat per pressed button.
// One item at a time; the next is taken while the last beat waits.
// Reset (async, active low) loads register defaults and clears integrals and errors.
`default_nettype none

module pan_tilt_tracking_controller #(
  parameter int unsigned INTEGRAL_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [2:0]                           cfg_index_i,
  input  logic [ptt_pkg::GAIN_W-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 command_i,
  input  logic [ptt_pkg::POS_FRAC_BITS-1:0]    face_x_i,
  input  logic [ptt_pkg::POS_FRAC_BITS-1:0]    face_y_i,
  input  logic                                 button_up_i,
  input  logic                                 button_down_i,
  input  logic                                 button_left_i,
  input  logic                                 button_right_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 axis_o,
  output logic [ptt_pkg::RUN_W-1:0]            run_time_o,
  output logic [ptt_pkg::DELAY_W-1:0]          step_delay_o,
  output logic                                 reverse_o,
  output logic                                 last_o
);
  import ptt_pkg::*;

  `include "pan_tilt_tracking_controller_macros.svh"

  localparam int unsigned IW     = INTEGRAL_WIDTH;
  localparam int unsigned EW     = POS_FRAC_BITS + 1;
  localparam int unsigned DW     = POS_FRAC_BITS + 2;
  localparam int unsigned NCHUNK = (IW + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned MAGW   = NCHUNK * CHUNK_W;
  localparam int unsigned PW     = GAIN_W + MAGW;
  localparam int unsigned TERM_W = 61;
  localparam int unsigned SATW   = (PW > TERM_W) ? PW : TERM_W;
  localparam int unsigned CKW    = $clog2(NCHUNK + 1);
  localparam int unsigned RT_SHIFT = 30;
  localparam int unsigned QUO_W    = 10;

  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_GAIN_P = 3'd1;
  localparam logic [2:0] CFG_GAIN_I = 3'd2;
  localparam logic [2:0] CFG_GAIN_D = 3'd3;
  localparam logic [2:0] CFG_DB     = 3'd4;

  localparam logic [1:0] MODE_TRACK  = 2'd1;
  localparam logic [1:0] MODE_MANUAL = 2'd2;

  localparam logic [1:0] TERM_P = 2'd0;
  localparam logic [1:0] TERM_I = 2'd1;
  localparam logic [1:0] TERM_D = 2'd2;

  localparam logic [EW-1:0]     POS_HALF   = EW'(1) << (POS_FRAC_BITS - 1);
  localparam logic [IW-1:0]     INT_MAX    = {1'b0, {(IW-1){1'b1}}};
  localparam logic [IW-1:0]     INT_MIN    = {1'b1, {(IW-1){1'b0}}};
  localparam logic [TERM_W-1:0] TERM_LIMIT = {1'b1, {(TERM_W-1){1'b0}}};
  localparam logic [RUN_W-1:0]  RUN_BASE   = 8'd198;
  localparam logic [RUN_W-1:0]  MAN_RUN    = 8'd195;
  localparam logic [DELAY_W-1:0] MAN_DELAY = 20'd2000;
  // ceil(2^30 / 1000): exact floor(delay / 1000) for every delay up to DELAY_MAX
  localparam logic [CHUNK_W-1:0] RECIP_M   = 24'd1073742;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MUL, S_TERM, S_DIV_GO, S_DIV_WAIT, S_RT_MUL, S_EMIT, S_MAN
  } state_e;

  function automatic logic [EW-1:0] axis_err(input logic [POS_FRAC_BITS-1:0] pos,
                                             input logic [DB_W-1:0] db);
    logic [EW-1:0] e;
    logic [EW-1:0] m;
    e = {1'b0, pos} - POS_HALF;
    m = e[EW-1] ? (~e + 1'b1) : e;
    return (m <= EW'(db)) ? '0 : e;
  endfunction

  function automatic logic [MAGW-1:0] mag_of(input logic [IW-1:0] v);
    logic [IW:0] w;
    w = {v[IW-1], v};
    if (v[IW-1]) begin
      w = ~w + 1'b1;
    end
    return MAGW'(w);
  endfunction

  // configuration
  logic [1:0]        mode_q;
  logic [GAIN_W-1:0] gain_p_q;
  logic [GAIN_W-1:0] gain_i_q;
  logic [GAIN_W-1:0] gain_d_q;
  logic [DB_W-1:0]   dead_band_q;

  // sequencer and datapath state
  state_e             state_q;
  logic               ax_q;
  logic [EW-1:0]      err_x_q;
  logic [EW-1:0]      err_y_q;
  logic [IW-1:0]      integ_x_q;
  logic [IW-1:0]      integ_y_q;
  logic [EW-1:0]      prev_x_q;
  logic [EW-1:0]      prev_y_q;
  logic [IW-1:0]      op_s_q;
  logic [DW-1:0]      op_d_q;
  logic [1:0]         t_q;
  logic [MAGW-1:0]    mag_sh_q;
  logic               term_neg_q;
  logic [CKW-1:0]     ck_left_q;
  logic               pend_q;
  logic [PW-1:0]      acc_q;
  logic [C_W-1:0]     c_acc_q;
  logic [DELAY_W-1:0] delay_q;
  logic [3:0]         btn_q;

  // output register
  logic               out_valid_q;
  logic               axis_q;
  logic [RUN_W-1:0]   run_q;
  logic [DELAY_W-1:0] step_delay_q;
  logic               reverse_q;
  logic               last_q;

  // combinational
  logic               in_acc;
  logic               slot_free;
  logic               out_load;
  logic [EW-1:0]      ex_new;
  logic [EW-1:0]      ey_raw;
  logic [EW+1:0]      ey3;
  logic [EW-1:0]      ey_new;
  logic [EW-1:0]      cur_e;
  logic [IW-1:0]      cur_integ;
  logic [EW-1:0]      cur_prev;
  logic [IW:0]        int_sum;
  logic [IW-1:0]      int_sat;
  logic [DW-1:0]      diff_e;
  logic [IW-1:0]      e_ext;
  logic [IW-1:0]      next_op;
  logic [GAIN_W-1:0]  gain_sel;
  logic [SATW-1:0]    acc_ext;
  logic [TERM_W-1:0]  tsat;
  logic [C_W-1:0]     tsat_ext;
  logic [C_W-1:0]     c_abs;
  logic               mul_en;
  logic [GAIN_W-1:0]  mul_a;
  logic [CHUNK_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [QUO_W-1:0]   quo;
  logic [RUN_W-1:0]   run_calc;
  logic [3:0]         btn_pick;
  logic [3:0]         btn_rest;
  logic               man_axis;
  logic               man_rev;
  ptt_div_stat_t      div_stat;
  logic [DELAY_W-1:0] div_quot;
  logic               div_start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= '0;
      gain_p_q    <= 20'd98304;
      gain_i_q    <= 20'd164;
      gain_d_q    <= 20'd164;
      dead_band_q <= 12'd164;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODE:   mode_q      <= cfg_data_i[1:0];
        CFG_GAIN_P: gain_p_q    <= cfg_data_i;
        CFG_GAIN_I: gain_i_q    <= cfg_data_i;
        CFG_GAIN_D: gain_d_q    <= cfg_data_i;
        CFG_DB:     dead_band_q <= cfg_data_i[DB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_acc    = in_valid_i && (state_q == S_IDLE);
    slot_free = !out_valid_q || !out_stall_i;
    out_load  = slot_free && ((state_q == S_EMIT) || (state_q == S_MAN));

    ex_new = axis_err(face_x_i, dead_band_q);
    ey_raw = axis_err(face_y_i, dead_band_q);
    // 3/4 scaling, rounded toward zero
    ey3 = {{2{ey_raw[EW-1]}}, ey_raw} + {ey_raw[EW-1], ey_raw, 1'b0};
    if (ey3[EW+1]) begin
      ey3 = ey3 + (EW+2)'(3);
    end
    ey_new = ey3[EW+1:2];

    cur_e     = ax_q ? err_y_q   : err_x_q;
    cur_integ = ax_q ? integ_y_q : integ_x_q;
    cur_prev  = ax_q ? prev_y_q  : prev_x_q;
    int_sum   = {cur_integ[IW-1], cur_integ} + {{(IW+1-EW){cur_e[EW-1]}}, cur_e};
    if (int_sum[IW] != int_sum[IW-1]) begin
      int_sat = int_sum[IW] ? INT_MIN : INT_MAX;
    end else begin
      int_sat = int_sum[IW-1:0];
    end
    diff_e = {cur_e[EW-1], cur_e} - {cur_prev[EW-1], cur_prev};
    e_ext  = {{(IW-EW){cur_e[EW-1]}}, cur_e};
    next_op = (t_q == TERM_P) ? op_s_q : {{(IW-DW){op_d_q[DW-1]}}, op_d_q};

    case (t_q)
      TERM_P:  gain_sel = gain_p_q;
      TERM_I:  gain_sel = gain_i_q;
      default: gain_sel = gain_d_q;
    endcase

    acc_ext  = SATW'(acc_q);
    tsat     = (acc_ext > SATW'(TERM_LIMIT)) ? TERM_LIMIT : acc_ext[TERM_W-1:0];
    tsat_ext = C_W'(tsat);
    c_abs    = c_acc_q[C_W-1] ? (~c_acc_q + 1'b1) : c_acc_q;

    mul_en = ((state_q == S_MUL) && (ck_left_q != '0)) || (state_q == S_RT_MUL);
    mul_a  = (state_q == S_RT_MUL) ? delay_q : gain_sel;
    mul_b  = (state_q == S_RT_MUL) ? RECIP_M : mag_sh_q[MAGW-1 -: CHUNK_W];

    quo      = mul_p[RT_SHIFT +: QUO_W];
    run_calc = (quo >= QUO_W'(RUN_BASE)) ? '0 : RUN_W'(QUO_W'(RUN_BASE) - quo);

    // button order: up, down, left, right
    if (btn_q[3]) begin
      btn_pick = 4'b1000; man_axis = 1'b1; man_rev = 1'b1;
    end else if (btn_q[2]) begin
      btn_pick = 4'b0100; man_axis = 1'b1; man_rev = 1'b0;
    end else if (btn_q[1]) begin
      btn_pick = 4'b0010; man_axis = 1'b0; man_rev = 1'b1;
    end else begin
      btn_pick = 4'b0001; man_axis = 1'b0; man_rev = 1'b0;
    end
    btn_rest = btn_q & ~btn_pick;

    div_start = (state_q == S_DIV_GO);
  end

  ptt_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  ptt_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (c_abs[DIV_W-1:0]),
    .stat_o    (div_stat),
    .quot_o    (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ax_q         <= 1'b0;
      err_x_q      <= '0;
      err_y_q      <= '0;
      integ_x_q    <= '0;
      integ_y_q    <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      op_s_q       <= '0;
      op_d_q       <= '0;
      t_q          <= TERM_P;
      mag_sh_q     <= '0;
      term_neg_q   <= 1'b0;
      ck_left_q    <= '0;
      pend_q       <= 1'b0;
      acc_q        <= '0;
      c_acc_q      <= '0;
      delay_q      <= '0;
      btn_q        <= '0;
      out_valid_q  <= 1'b0;
      axis_q       <= 1'b0;
      run_q        <= '0;
      step_delay_q <= '0;
      reverse_q    <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if ((mode_q == MODE_TRACK) && !command_i) begin
              err_x_q <= ex_new;
              err_y_q <= ey_new;
              ax_q    <= 1'b0;
              state_q <= S_PREP;
            end else if ((mode_q == MODE_MANUAL) && command_i &&
                         (button_up_i || button_down_i || button_left_i || button_right_i)) begin
              btn_q   <= {button_up_i, button_down_i, button_left_i, button_right_i};
              state_q <= S_MAN;
            end
          end
        end

        S_PREP: begin
          if (ax_q) begin
            integ_y_q <= int_sat;
            prev_y_q  <= cur_e;
          end else begin
            integ_x_q <= int_sat;
            prev_x_q  <= cur_e;
          end
          op_s_q     <= int_sat;
          op_d_q     <= diff_e;
          t_q        <= TERM_P;
          mag_sh_q   <= mag_of(e_ext);
          term_neg_q <= cur_e[EW-1];
          ck_left_q  <= CKW'(NCHUNK);
          pend_q     <= 1'b0;
          acc_q      <= '0;
          c_acc_q    <= '0;
          state_q    <= S_MUL;
        end

        S_MUL: begin
          // top chunk first; the product lands in the cycle after issue
          if (ck_left_q != '0) begin
            mag_sh_q  <= mag_sh_q << CHUNK_W;
            ck_left_q <= ck_left_q - 1'b1;
          end
          pend_q <= (ck_left_q != '0);
          if (pend_q) begin
            acc_q <= (acc_q << CHUNK_W) + PW'(mul_p);
          end
          if ((ck_left_q == '0) && pend_q) begin
            state_q <= S_TERM;
          end
        end

        S_TERM: begin
          c_acc_q <= term_neg_q ? (c_acc_q - tsat_ext) : (c_acc_q + tsat_ext);
          if (t_q == TERM_D) begin
            state_q <= S_DIV_GO;
          end else begin
            t_q        <= t_q + 1'b1;
            mag_sh_q   <= mag_of(next_op);
            term_neg_q <= next_op[IW-1];
            ck_left_q  <= CKW'(NCHUNK);
            pend_q     <= 1'b0;
            acc_q      <= '0;
            state_q    <= S_MUL;
          end
        end

        S_DIV_GO: begin
          state_q <= S_DIV_WAIT;
        end

        S_DIV_WAIT: begin
          if (div_stat.done) begin
            delay_q <= div_quot;
            state_q <= S_RT_MUL;
          end
        end

        S_RT_MUL: begin
          state_q <= S_EMIT;
        end

        S_EMIT: begin
          if (slot_free) begin
            axis_q       <= ax_q;
            run_q        <= run_calc;
            step_delay_q <= delay_q;
            reverse_q    <= c_acc_q[C_W-1];
            last_q       <= ax_q;
            if (ax_q) begin
              state_q <= S_IDLE;
            end else begin
              ax_q    <= 1'b1;
              state_q <= S_PREP;
            end
          end
        end

        S_MAN: begin
          if (slot_free) begin
            axis_q       <= man_axis;
            run_q        <= MAN_RUN;
            step_delay_q <= MAN_DELAY;
            reverse_q    <= man_rev;
            last_q       <= (btn_rest == '0);
            btn_q        <= btn_rest;
            if (btn_rest == '0) begin
              state_q <= S_IDLE;
            end
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign axis_o       = axis_q;
  assign run_time_o   = run_q;
  assign step_delay_o = step_delay_q;
  assign reverse_o    = reverse_q;
  assign last_o       = last_q;

  `PTT_ASSERT_IMP(a_delay_range, out_valid_o, step_delay_o <= DELAY_MAX)
  `PTT_ASSERT_IMP(a_sat_run_zero, out_valid_o && (step_delay_o == DELAY_MAX), run_time_o == '0)
  `PTT_ASSERT_IMP(a_no_overwrite, out_load && out_valid_q, !out_stall_i)
  `PTT_ASSERT_NXT(a_div_started, state_q == S_DIV_GO, div_stat.busy || div_stat.done)

endmodule

`default_nettype wire

/* rtl/core/ptt_mul.sv */
// Shared unsigned multiplier with registered product.
// Depends on ptt_pkg.
`default_nettype none

module ptt_mul (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [ptt_pkg::GAIN_W-1:0]    a_i,
  input  logic [ptt_pkg::CHUNK_W-1:0]   b_i,
  output logic [ptt_pkg::MUL_P_W-1:0]   p_o
);
  import ptt_pkg::*;

  logic [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

/* rtl/core/ptt_div.sv */
// Serial restoring divider for the step delay: DIV_NUM / divisor, one bit a cycle,
// saturated at DELAY_MAX. Depends on ptt_pkg.
`default_nettype none

module ptt_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ptt_pkg::DIV_W-1:0]     divisor_i,
  output ptt_pkg::ptt_div_stat_t        stat_o,
  output logic [ptt_pkg::DELAY_W-1:0]   quot_o
);
  import ptt_pkg::*;

  localparam int unsigned STEPS = DELAY_W;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIV_W-1:0]  rem_q;
  logic [DIV_W-1:0]  den_q;
  logic [STEPS-1:0]  num_q;
  logic [STEPS-1:0]  quot_q;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              fits;

  always_comb begin
    trial = {rem_q, num_q[STEPS-1]};
    diff  = trial - {1'b0, den_q};
    fits  = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      num_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        den_q <= divisor_i;
        if (divisor_i <= DIV_W'(DIV_SAT_T)) begin
          quot_q <= DELAY_MAX;
          done_q <= 1'b1;
        end else begin
          // quotient fits STEPS bits, so the high numerator bits are a plain preload
          rem_q  <= DIV_W'(DIV_NUM >> STEPS);
          num_q  <= DIV_NUM[STEPS-1:0];
          quot_q <= '0;
          cnt_q  <= CNT_W'(STEPS);
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        rem_q  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        quot_q <= {quot_q[STEPS-2:0], fits};
        num_q  <= num_q << 1;
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

`default_nettype wire
